### hdl/srms_pkg.sv
// Shared types, constants and arithmetic helpers for the sparse row matrix store.
package srms_pkg;

    localparam int ROWS      = 1024;
    localparam int ROW_CAP   = 8;
    localparam int RIDX_W    = $clog2(ROWS);
    localparam int SLOT_W    = $clog2(ROW_CAP);
    localparam int LEN_W     = $clog2(ROW_CAP + 1);
    localparam int VAL_W     = 32;
    localparam int TOT_W     = 14;
    localparam int ENT_DEPTH = ROWS * ROW_CAP;
    localparam int ENT_AW    = RIDX_W + SLOT_W;
    localparam int ENT_W     = RIDX_W + VAL_W;
    localparam int MODE_W    = 3;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 16;

    // Mode field codes
    localparam logic [MODE_W-1:0] MODE_SET  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HAS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOAD = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PROD = 3'd5;

    // Classified operation
    typedef enum logic [2:0] {
        OP_SET,
        OP_ADD,
        OP_GET,
        OP_HAS,
        OP_LOAD,
        OP_PROD,
        OP_NOP
    } op_t;

    // Command from the front to the back
    typedef struct packed {
        op_t                      op;
        logic [RIDX_W-1:0]        row;
        logic [RIDX_W-1:0]        column;
        logic signed [VAL_W-1:0]  value;
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic                     found;
        logic                     status;
        logic [TOT_W-1:0]         total;
    } result_t;

    // Saturating 32-bit add
    function automatic logic signed [VAL_W-1:0] sat_add_val(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            sat_add_val = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else
            sat_add_val = s[VAL_W-1:0];
    endfunction

    // Saturating 64-bit add
    function automatic logic signed [ACC_W-1:0] sat_add_acc(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            sat_add_acc = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sat_add_acc = s[ACC_W-1:0];
    endfunction

    // Arithmetic shift right by the fraction width, then saturate to value width
    function automatic logic signed [VAL_W-1:0] shr_sat(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-FRAC_W-VAL_W:0] top;
        top = a[ACC_W-1:FRAC_W+VAL_W-1];
        if (top == '0 || top == '1)
            shr_sat = a[FRAC_W+VAL_W-1:FRAC_W];
        else
            shr_sat = a[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

endpackage

### hdl/srms_front.sv
// Front end: accepts input transactions, classifies the mode, queues commands.
module srms_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [srms_pkg::MODE_W-1:0]        mode,
    input  logic [srms_pkg::RIDX_W-1:0]        row,
    input  logic [srms_pkg::RIDX_W-1:0]        column,
    input  logic signed [srms_pkg::VAL_W-1:0]  value,
    input  logic                               init_done,
    output logic                               cmd_valid,
    output srms_pkg::cmd_t                     cmd,
    input  logic                               cmd_take
);

    srms_pkg::cmd_t q_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     cnt_reg;
    srms_pkg::op_t  op_dec;
    logic           do_push;

    // Mode decode
    always_comb
    begin
        unique case (mode)
            srms_pkg::MODE_SET:  op_dec = srms_pkg::OP_SET;
            srms_pkg::MODE_ADD:  op_dec = srms_pkg::OP_ADD;
            srms_pkg::MODE_GET:  op_dec = srms_pkg::OP_GET;
            srms_pkg::MODE_HAS:  op_dec = srms_pkg::OP_HAS;
            srms_pkg::MODE_LOAD: op_dec = srms_pkg::OP_LOAD;
            srms_pkg::MODE_PROD: op_dec = srms_pkg::OP_PROD;
            default:             op_dec = srms_pkg::OP_NOP;
        endcase
    end

    assign full      = (cnt_reg == 2'd2) || !init_done;
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];

    // Two-entry command queue payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= '{op: op_dec, row: row, column: column, value: value};
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (cmd_take)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, cmd_take};
        end
    end

endmodule

### hdl/srms_back.sv
// Back end: sequencer over the entry, row length and vector memories.
module srms_back (
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 init_done,
    input  logic                 cmd_valid,
    input  srms_pkg::cmd_t       cmd,
    output logic                 cmd_take,
    output logic                 res_push,
    output srms_pkg::result_t    res,
    input  logic                 res_full
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LEN, S_DISP, S_RD, S_CMP, S_ACT, S_SHR, S_SHW,
        S_LOAD, S_PRD, S_PV, S_PM, S_PA, S_OUT
    } state_t;

    localparam int RW = srms_pkg::RIDX_W;
    localparam int VW = srms_pkg::VAL_W;
    localparam int LW = srms_pkg::LEN_W;
    localparam int SW = srms_pkg::SLOT_W;

    // Memories
    logic [srms_pkg::ENT_W-1:0] ent_mem [srms_pkg::ENT_DEPTH];
    logic [LW-1:0]              rl_mem  [srms_pkg::ROWS];
    logic [VW-1:0]              vec_mem [srms_pkg::ROWS];

    logic [srms_pkg::ENT_W-1:0]  ent_rdata;
    logic [LW-1:0]               rl_rdata;
    logic signed [VW-1:0]        vec_rdata;
    logic [srms_pkg::ENT_AW-1:0] ent_raddr, ent_waddr;
    logic [srms_pkg::ENT_W-1:0]  ent_wdata;
    logic                        ent_we, rl_we, vec_we;
    logic [RW-1:0]               rl_waddr, vec_waddr;
    logic [LW-1:0]               rl_wdata;
    logic [VW-1:0]               vec_wdata;
    logic [RW-1:0]               rd_col;
    logic signed [VW-1:0]        rd_val, nv;
    logic [LW-1:0]               k_dec;

    state_t                          state_reg, state_next;
    logic [RW-1:0]                   clr_reg, clr_next;
    srms_pkg::op_t                   op_reg, op_next;
    logic [RW-1:0]                   row_reg, row_next, col_reg, col_next;
    logic signed [VW-1:0]            value_reg, value_next;
    logic [LW-1:0]                   len_reg, len_next, k_reg, k_next, pos_reg, pos_next;
    logic signed [VW-1:0]            val_reg, val_next, nv_reg, nv_next;
    logic signed [srms_pkg::ACC_W-1:0] acc_reg, acc_next, prod_reg, prod_next;
    logic signed [VW-1:0]            resv_reg, resv_next;
    logic                            found_reg, found_next, status_reg, status_next;
    logic [srms_pkg::TOT_W-1:0]      total_reg, total_next;

    assign rd_col    = ent_rdata[srms_pkg::ENT_W-1:VW];
    assign rd_val    = ent_rdata[VW-1:0];
    assign k_dec     = k_reg - LW'(1);
    assign init_done = (state_reg != S_CLR);
    assign res       = '{value: resv_reg, found: found_reg, status: status_reg,
                         total: total_reg};
    assign ent_raddr = (state_reg == S_SHR) ? {row_reg, k_dec[SW-1:0]}
                                            : {row_reg, k_reg[SW-1:0]};
    assign nv = (op_reg == srms_pkg::OP_SET) ? value_reg
              : srms_pkg::sat_add_val(found_reg ? val_reg : '0, value_reg);

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_rdata <= ent_mem[ent_raddr];
    end

    // Row length memory
    always_ff @(posedge clk)
    begin
        if (rl_we)
            rl_mem[rl_waddr] <= rl_wdata;
        rl_rdata <= rl_mem[row_reg];
    end

    // Vector memory
    always_ff @(posedge clk)
    begin
        if (vec_we)
            vec_mem[vec_waddr] <= vec_wdata;
        vec_rdata <= vec_mem[rd_col];
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        value_next  = value_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        nv_next     = nv_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        resv_next   = resv_reg;
        found_next  = found_reg;
        status_next = status_reg;
        total_next  = total_reg;
        cmd_take    = 1'b0;
        res_push    = 1'b0;
        ent_we      = 1'b0;
        ent_waddr   = {row_reg, pos_reg[SW-1:0]};
        ent_wdata   = {col_reg, nv};
        rl_we       = 1'b0;
        rl_waddr    = row_reg;
        rl_wdata    = len_reg + LW'(1);
        vec_we      = 1'b0;
        vec_waddr   = col_reg;
        vec_wdata   = value_reg;

        unique case (state_reg)
            S_CLR:
            begin
                rl_we     = 1'b1;
                rl_waddr  = clr_reg;
                rl_wdata  = '0;
                vec_we    = 1'b1;
                vec_waddr = clr_reg;
                vec_wdata = '0;
                clr_next  = clr_reg + RW'(1);
                if (clr_reg == RW'(srms_pkg::ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take    = 1'b1;
                    op_next     = cmd.op;
                    row_next    = cmd.row;
                    col_next    = cmd.column;
                    value_next  = cmd.value;
                    k_next      = '0;
                    acc_next    = '0;
                    resv_next   = '0;
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    if (cmd.op == srms_pkg::OP_LOAD)
                        state_next = S_LOAD;
                    else if (cmd.op == srms_pkg::OP_NOP)
                        state_next = S_OUT;
                    else
                        state_next = S_LEN;
                end
            end
            S_LEN:
                state_next = S_DISP;
            S_DISP:
            begin
                len_next = (rl_rdata > LW'(srms_pkg::ROW_CAP)) ? LW'(srms_pkg::ROW_CAP)
                                                                : rl_rdata;
                state_next = (op_reg == srms_pkg::OP_PROD) ? S_PRD : S_RD;
            end
            // Scan the row for the first column not below the target
            S_RD:
            begin
                if (k_reg < len_reg)
                    state_next = S_CMP;
                else
                begin
                    pos_next   = len_reg;
                    state_next = S_ACT;
                end
            end
            S_CMP:
            begin
                if (rd_col < col_reg)
                begin
                    k_next     = k_reg + LW'(1);
                    state_next = S_RD;
                end
                else
                begin
                    pos_next   = k_reg;
                    found_next = (rd_col == col_reg);
                    val_next   = rd_val;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_OUT;
                case (op_reg)
                    srms_pkg::OP_GET:
                        resv_next = found_reg ? val_reg : '0;
                    srms_pkg::OP_SET, srms_pkg::OP_ADD:
                    begin
                        if (found_reg)
                        begin
                            ent_we    = 1'b1;
                            resv_next = nv;
                        end
                        else if (len_reg >= LW'(srms_pkg::ROW_CAP))
                            status_next = 1'b1;
                        else
                        begin
                            nv_next    = nv;
                            k_next     = len_reg;
                            state_next = S_SHR;
                        end
                    end
                    default:
                        resv_next = '0;
                endcase
            end
            // Open a gap at pos by moving later entries up one slot
            S_SHR:
            begin
                if (k_reg > pos_reg)
                    state_next = S_SHW;
                else
                begin
                    ent_we     = 1'b1;
                    ent_wdata  = {col_reg, nv_reg};
                    rl_we      = 1'b1;
                    total_next = total_reg + srms_pkg::TOT_W'(1);
                    resv_next  = nv_reg;
                    state_next = S_OUT;
                end
            end
            S_SHW:
            begin
                ent_we     = 1'b1;
                ent_waddr  = {row_reg, k_reg[SW-1:0]};
                ent_wdata  = ent_rdata;
                k_next     = k_dec;
                state_next = S_SHR;
            end
            S_LOAD:
            begin
                vec_we     = 1'b1;
                resv_next  = value_reg;
                state_next = S_OUT;
            end
            // Row dot product: read entry, read vector, multiply, accumulate
            S_PRD:
            begin
                if (k_reg < len_reg)
                    state_next = S_PV;
                else
                begin
                    resv_next  = srms_pkg::shr_sat(acc_reg);
                    state_next = S_OUT;
                end
            end
            S_PV:
            begin
                val_next   = rd_val;
                state_next = S_PM;
            end
            S_PM:
            begin
                prod_next  = vec_rdata * val_reg;
                state_next = S_PA;
            end
            S_PA:
            begin
                acc_next   = srms_pkg::sat_add_acc(acc_reg, prod_reg);
                k_next     = k_reg + LW'(1);
                state_next = S_PRD;
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            total_reg  <= '0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            total_reg  <= total_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        len_reg   <= len_next;
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        nv_reg    <= nv_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        resv_reg  <= resv_next;
    end

endmodule

### hdl/srms_outq.sv
// Result queue: two-entry buffer between the back end and the result port.
module srms_outq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               res_push,
    input  srms_pkg::result_t                  res,
    output logic                               res_full,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [srms_pkg::VAL_W-1:0]  result_value,
    output logic                               found,
    output logic                               status,
    output logic [srms_pkg::TOT_W-1:0]         total_entries
);

    srms_pkg::result_t q_reg [2];
    logic              wptr_reg, rptr_reg;
    logic [1:0]        cnt_reg;
    logic              do_pop;

    assign res_full      = (cnt_reg == 2'd2);
    assign empty         = (cnt_reg == 2'd0);
    assign do_pop        = pop && !empty;
    assign result_value  = q_reg[rptr_reg].value;
    assign found         = q_reg[rptr_reg].found;
    assign status        = q_reg[rptr_reg].status;
    assign total_entries = q_reg[rptr_reg].total;

    // Payload
    always_ff @(posedge clk)
    begin
        if (res_push)
            q_reg[wptr_reg] <= res;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, res_push} - {1'b0, do_pop};
        end
    end

endmodule

### hdl/sparse_row_matrix_store_top.sv
// Sparse row matrix store: front decode, command queue, sequencer back end, result queue.
// Holds a 1024x1024 sparse matrix (up to 8 column-sorted entries per row) and a
// 1024-element vector, values in signed Q16.16. After reset a clearing pass zeroes
// row lengths and the vector; full stays high during it. Items then run one at a time
// in the back-end sequencer, which has one read and one write port per memory: set, add,
// get and contains scan the row slot by slot, and an insert then shifts later slots up;
// row product steps through each stored entry in the row (entry read, vector read,
// multiply, saturating accumulate); load writes the vector. Two commands and two
// results can wait in the queues on either side.
module sparse_row_matrix_store_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [srms_pkg::MODE_W-1:0]        mode,
    input  logic [srms_pkg::RIDX_W-1:0]        row,
    input  logic [srms_pkg::RIDX_W-1:0]        column,
    input  logic signed [srms_pkg::VAL_W-1:0]  value,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [srms_pkg::VAL_W-1:0]  result_value,
    output logic                               found,
    output logic                               status,
    output logic [srms_pkg::TOT_W-1:0]         total_entries
);

    logic              init_done, cmd_valid, cmd_take, res_push, res_full;
    srms_pkg::cmd_t    cmd;
    srms_pkg::result_t res;

    srms_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode), .row(row),
        .column(column), .value(value), .init_done(init_done), .cmd_valid(cmd_valid),
        .cmd(cmd), .cmd_take(cmd_take)
    );

    srms_back u_back (
        .clk(clk), .rst_n(rst_n), .init_done(init_done), .cmd_valid(cmd_valid),
        .cmd(cmd), .cmd_take(cmd_take), .res_push(res_push), .res(res),
        .res_full(res_full)
    );

    srms_outq u_outq (
        .clk(clk), .rst_n(rst_n), .res_push(res_push), .res(res), .res_full(res_full),
        .empty(empty), .pop(pop), .result_value(result_value), .found(found),
        .status(status), .total_entries(total_entries)
    );

endmodule

### hdl/srms_checker.sv
// Port-level checker for the sparse row matrix store, bound to the top level.
module srms_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic signed [srms_pkg::VAL_W-1:0]  result_value,
    input logic                               found,
    input logic                               status,
    input logic [srms_pkg::TOT_W-1:0]         total_entries
);

    // A waiting result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");

    // A waiting result does not change
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result_value) && $stable(found) && $stable(status)
                           && $stable(total_entries))
        else $error("waiting result changed");

    // A refused insert reports an absent entry and a zero value
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status |-> !found && result_value == '0)
        else $error("refused insert with nonzero value or found");

    // Entry count never drops between consecutive results
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop ##1 !empty |-> total_entries >= $past(total_entries))
        else $error("entry count decreased");

endmodule

bind sparse_row_matrix_store_top srms_checker u_srms_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .result_value(result_value),
    .found(found), .status(status), .total_entries(total_entries)
);

### verif/tb_sparse_row_matrix_store_top.sv
// Self-checking testbench for the sparse row matrix store: queued driver, monitor, predictor.
module tb_sparse_row_matrix_store_top;

    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    // Mode codes with no operation behind them
    localparam logic [srms_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [srms_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        logic [srms_pkg::MODE_W-1:0]       mode;
        logic [srms_pkg::RIDX_W-1:0]       row;
        logic [srms_pkg::RIDX_W-1:0]       column;
        logic signed [srms_pkg::VAL_W-1:0] value;
    } txn_t;

    typedef struct {
        logic signed [srms_pkg::VAL_W-1:0] value;
        logic                              found;
        logic                              status;
        logic [srms_pkg::TOT_W-1:0]        total;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, found, status;
    logic [srms_pkg::MODE_W-1:0] mode = '0;
    logic [srms_pkg::RIDX_W-1:0] row = '0;
    logic [srms_pkg::RIDX_W-1:0] column = '0;
    logic signed [srms_pkg::VAL_W-1:0] value = '0;
    logic signed [srms_pkg::VAL_W-1:0] result_value;
    logic [srms_pkg::TOT_W-1:0] total_entries;

    // Predictor state
    logic [srms_pkg::RIDX_W-1:0]       mdl_cols [srms_pkg::ROWS][srms_pkg::ROW_CAP];
    logic signed [srms_pkg::VAL_W-1:0] mdl_vals [srms_pkg::ROWS][srms_pkg::ROW_CAP];
    int                                mdl_len  [srms_pkg::ROWS];
    logic signed [srms_pkg::VAL_W-1:0] mdl_vec  [srms_pkg::ROWS];
    int                                mdl_total;

    txn_t    pending_txns[$];
    answer_t expected_answers[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  hold_left = 0;

    // Sampled full at the last rising edge, tells the driver whether its item went in
    logic full_seen = 1'b1;

    sparse_row_matrix_store_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode), .row(row),
        .column(column), .value(value), .empty(empty), .pop(pop),
        .result_value(result_value), .found(found), .status(status),
        .total_entries(total_entries)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [srms_pkg::VAL_W-1:0] clamp_val(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[srms_pkg::VAL_W-1:0];
    endfunction

    // Compute the answer for one accepted transaction and update predictor state
    function automatic answer_t predict_answer(txn_t t);
        answer_t a;
        int len, pos, k;
        longint acc, prod, sum;
        a.value = '0; a.found = 0; a.status = 0;
        if (t.mode <= srms_pkg::MODE_HAS)
        begin
            len = mdl_len[t.row];
            pos = 0;
            while (pos < len && mdl_cols[t.row][pos] < t.column) pos++;
            a.found = (pos < len && mdl_cols[t.row][pos] == t.column);
            if (t.mode == srms_pkg::MODE_SET || t.mode == srms_pkg::MODE_ADD)
            begin
                if (t.mode == srms_pkg::MODE_SET)
                    a.value = t.value;
                else
                    a.value = clamp_val((a.found ? longint'(mdl_vals[t.row][pos]) : 0)
                                        + longint'(t.value));
                if (a.found)
                    mdl_vals[t.row][pos] = a.value;
                else if (len >= srms_pkg::ROW_CAP)
                begin
                    a.status = 1;
                    a.value = '0;
                end
                else
                begin
                    for (k = len; k > pos; k--)
                    begin
                        mdl_cols[t.row][k] = mdl_cols[t.row][k-1];
                        mdl_vals[t.row][k] = mdl_vals[t.row][k-1];
                    end
                    mdl_cols[t.row][pos] = t.column;
                    mdl_vals[t.row][pos] = a.value;
                    mdl_len[t.row] = len + 1;
                    mdl_total++;
                end
            end
            else if (t.mode == srms_pkg::MODE_GET && a.found)
                a.value = mdl_vals[t.row][pos];
        end
        else if (t.mode == srms_pkg::MODE_LOAD)
        begin
            mdl_vec[t.column] = t.value;
            a.value = t.value;
        end
        else if (t.mode == srms_pkg::MODE_PROD)
        begin
            acc = 0;
            for (k = 0; k < mdl_len[t.row]; k++)
            begin
                prod = longint'(mdl_vec[mdl_cols[t.row][k]]) * longint'(mdl_vals[t.row][k]);
                sum = acc + prod;
                if (prod > 0 && sum < acc) sum = 64'h7fffffffffffffff;
                if (prod < 0 && sum > acc) sum = 64'h8000000000000000;
                acc = sum;
            end
            a.value = clamp_val(acc >>> srms_pkg::FRAC_W);
        end
        a.total = srms_pkg::TOT_W'(mdl_total);
        return a;
    endfunction

    // Driver: present queued transactions at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full_seen)
                void'(pending_txns.pop_front());
            if (pending_txns.size() > 0 && (calm || $urandom_range(99) >= 34))
            begin
                push <= 1'b1;
                mode <= pending_txns[0].mode;
                row <= pending_txns[0].row;
                column <= pending_txns[0].column;
                value <= pending_txns[0].value;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver readiness, with one long hold-off counted here
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(99) >= 34);
        end
    end

    // Monitor: accept both sides at the rising edge
    always @(posedge clk)
    begin
        answer_t got, want;
        bit moved;
        moved = 1'b0;
        full_seen <= full;
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_answers.insert(expected_answers.size(),
                                        predict_answer('{mode, row, column, value}));
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                got = '{result_value, found, status, total_entries};
                if (expected_answers.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("result_value exp %0d got %0d", want.value, got.value);
                        fail_count++;
                    end
                    if (got.found !== want.found)
                    begin
                        $error("found exp %0d got %0d", want.found, got.found);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.total !== want.total)
                    begin
                        $error("total_entries exp %0d got %0d", want.total, got.total);
                        fail_count++;
                    end
                end
            end
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic queue_txn(int m, int r, int c, logic signed [srms_pkg::VAL_W-1:0] v);
        txn_t t;
        t.mode = srms_pkg::MODE_W'(m);
        t.row = srms_pkg::RIDX_W'(r);
        t.column = srms_pkg::RIDX_W'(c);
        t.value = v;
        pending_txns.insert(pending_txns.size(), t);
    endtask

    // Random transaction biased to a few hot rows so rows fill and collide
    task automatic queue_random();
        int m, r, c, sel;
        logic signed [srms_pkg::VAL_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 25) m = srms_pkg::MODE_SET;
        else if (sel < 45) m = srms_pkg::MODE_ADD;
        else if (sel < 57) m = srms_pkg::MODE_GET;
        else if (sel < 67) m = srms_pkg::MODE_HAS;
        else if (sel < 82) m = srms_pkg::MODE_LOAD;
        else if (sel < 97) m = srms_pkg::MODE_PROD;
        else m = $urandom_range(1) ? MODE_SPARE_B : MODE_SPARE_A;
        r = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(7);
        c = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $signed($urandom_range(65535)) - 32768;
            2: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: v = $signed($urandom_range(2 * 65536 * 8)) - 65536 * 8;
        endcase
        queue_txn(m, r, c, v);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < srms_pkg::ROWS; i++)
        begin
            mdl_len[i] = 0;
            mdl_vec[i] = '0;
        end
        mdl_total = 0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: extremes, every mode, full row, saturation, unknown modes
        queue_txn(srms_pkg::MODE_GET, 1023, 1023, 0);
        queue_txn(srms_pkg::MODE_HAS, 0, 0, 0);
        queue_txn(srms_pkg::MODE_PROD, 5, 0, 0);
        queue_txn(srms_pkg::MODE_LOAD, 0, 0, 32'sh7fffffff);
        queue_txn(srms_pkg::MODE_LOAD, 1023, 1023, 32'sh80000000);
        for (i = 0; i < 9; i++)
            queue_txn(srms_pkg::MODE_SET, 1023, 1023 - 100 * i, 32'sh7fffffff);
        queue_txn(srms_pkg::MODE_ADD, 1023, 5, 1);
        queue_txn(srms_pkg::MODE_ADD, 1023, 1023, 32'sh7fffffff);
        queue_txn(srms_pkg::MODE_PROD, 1023, 0, 0);
        queue_txn(srms_pkg::MODE_SET, 0, 0, 32'sh80000000);
        queue_txn(srms_pkg::MODE_ADD, 0, 0, 32'sh80000000);
        queue_txn(srms_pkg::MODE_HAS, 0, 0, 0);
        queue_txn(srms_pkg::MODE_PROD, 0, 1023, 32'sh55555555);
        queue_txn(MODE_SPARE_A, 3, 3, 7);
        queue_txn(MODE_SPARE_B, 1023, 1023, 32'shffffffff);
        queue_txn(srms_pkg::MODE_ADD, 2, 9, -5);

        // Long calm stretch, then a receiver hold-off to fill the queues
        calm = 1;
        for (i = 0; i < 200; i++) queue_random();
        while (pending_txns.size() >= 150) @(posedge clk);
        calm = 0;
        hold_req = 1;
        for (i = 0; i < 1600; i++) queue_random();

        while (pending_txns.size() > 0 || push) @(posedge clk);
        while (expected_answers.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_answers.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/srms_pkg.sv
hdl/srms_front.sv
hdl/srms_back.sv
hdl/srms_outq.sv
hdl/sparse_row_matrix_store_top.sv
hdl/srms_checker.sv
verif/tb_sparse_row_matrix_store_top.sv
